// ===== hdl/sida_pkg.sv =====
package sida_pkg;

	// ASCII codes, trimmed to the 6-bit character port
	localparam logic [5:0] CHAR_MINUS = 6'd45;
	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_NINE  = 6'd57;

	// BCD digit adjust threshold and offset for shift-add-3
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII text. Pulse start while busy is low to take
// one request: a two's complement value (low VALUE_BITS bits of value, the top
// one the sign). The block answers with its decimal text, most significant
// character first, one character per strobe cycle: an optional '-' and then
// the digits with no leading zeros ("0" for zero). last_char marks the final
// character. The receiver cannot stall: each character is on text_char for
// exactly one cycle, so it must be taken when strobe is high. At most
// MAX_CHARS characters (the cap clamped to 1..21) go out; longer text is cut
// after its most significant part, the final one kept still carrying
// last_char. A request occupies the block for binary-to-BCD conversion (one
// shift-add-3 pass of the shared digit adjust unit per input bit), then
// leading-zero skip (ND = digit capacity, 10 for 32 bits), then sending the
// characters. busy drops in the cycle the last character is shown, so the
// next request may start then. No state carries between requests.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_CHARS  = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	output logic               strobe,
	output logic        [5:0]  text_char,
	output logic               last_char
);

	// decimal digits needed for any VALUE_BITS-bit unsigned magnitude
	localparam int ND       = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS = ND * 4;
	// output length cap, clamped to the range 1..21
	localparam int LIM_HI   = (MAX_CHARS > 21) ? 21 : MAX_CHARS;
	localparam int LIM      = (LIM_HI < 1) ? 1 : LIM_HI;
	localparam int BW       = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int DW       = $clog2(ND + 1);
	localparam int CW       = $clog2(LIM + 1);
	localparam int EXT_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   bin_q;      // magnitude bits still to shift in
	logic [BCD_BITS-1:0]     bcd_q;      // BCD digits, most significant on top
	logic [BW-1:0]           bit_cnt_q;  // conversion steps left minus one
	logic [DW-1:0]           dig_left_q; // digits not yet skipped or sent
	logic [CW-1:0]           chars_q;    // characters sent so far
	logic                    neg_q;
	logic                    strobe_q;
	logic [5:0]              char_q;
	logic                    last_q;

	logic [EXT_BITS-1:0]     value_ext;
	logic [VALUE_BITS-1:0]   x;
	logic                    x_neg;
	logic [VALUE_BITS-1:0]   x_mag;
	logic [BCD_BITS-1:0]     bcd_adj;
	logic [3:0]              top_digit;
	logic                    cap_hit;

	// high bits beyond VALUE_BITS are ignored; a narrow port reads as zero above
	assign value_ext = EXT_BITS'($unsigned(value));
	assign x         = value_ext[VALUE_BITS-1:0];
	assign x_neg     = x[VALUE_BITS-1];
	// the unsigned magnitude also holds 2^(VALUE_BITS-1) for the most negative value
	assign x_mag     = x_neg ? (VALUE_BITS'(0) - x) : x;

	// shared shift-add-3 unit: every digit lane adjusts before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[i*4 +: 4] >= sida_pkg::BCD_ADJ_MIN) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + sida_pkg::BCD_ADJ_ADD;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BCD_BITS-1 -: 4];
	// next character sent is the last one the length cap allows
	assign cap_hit   = (chars_q == CW'(LIM - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						bin_q      <= x_mag;
						bcd_q      <= '0;
						neg_q      <= x_neg;
						bit_cnt_q  <= BW'(VALUE_BITS - 1);
						dig_left_q <= DW'(ND);
						chars_q    <= '0;
						state_q    <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BCD_BITS-2:0], bin_q[VALUE_BITS-1]};
					bin_q     <= bin_q << 1;
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, keep at least one digit
					if (top_digit == 4'd0 && dig_left_q > DW'(1)) begin
						bcd_q      <= bcd_q << 4;
						dig_left_q <= dig_left_q - 1'b1;
					end else if (neg_q) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_DIGITS;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					char_q   <= sida_pkg::CHAR_MINUS;
					last_q   <= cap_hit;
					chars_q  <= chars_q + 1'b1;
					state_q  <= cap_hit ? ST_IDLE : ST_DIGITS;
				end
				ST_DIGITS: begin
					strobe_q   <= 1'b1;
					char_q     <= sida_pkg::CHAR_ZERO + {2'b00, top_digit};
					last_q     <= cap_hit || (dig_left_q == DW'(1));
					bcd_q      <= bcd_q << 4;
					dig_left_q <= dig_left_q - 1'b1;
					chars_q    <= chars_q + 1'b1;
					if (cap_hit || dig_left_q == DW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign text_char = char_q;
	assign last_char = last_q;

`ifndef ASSERT_OFF
	// a character only follows a cycle in which a request was in progress
	a_strobe_in_request: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("strobe without a request in progress");

	// last marker only rides on a character
	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> strobe)
		else $error("last_char without strobe");

	// more characters are due while the run is not finished
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_char) |-> busy)
		else $error("run ended without last_char");

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// only minus or a digit leaves the block
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (text_char == sida_pkg::CHAR_MINUS ||
			(text_char >= sida_pkg::CHAR_ZERO && text_char <= sida_pkg::CHAR_NINE)))
		else $error("illegal character code");
`endif

endmodule
